### hdl/batch_norm_forward_unit_assert.svh
// Assertion macros for the batch normalization unit.
`ifndef BATCH_NORM_FORWARD_UNIT_ASSERT_SVH
`define BATCH_NORM_FORWARD_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BNF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BNF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bnf_pkg.sv
// Shared types, constants and helpers of the batch normalization unit.
package bnf_pkg;

    // defaults for the top-level parameters
    localparam int MAX_BATCH_DEF = 64;
    localparam int FEATURES_DEF  = 256;

    // widest feature table index (FEATURES up to 4096)
    localparam int FIDX_MAX_W = 12;

    // command queue between front and back
    localparam int Q_DEPTH = 4;

    // divider geometry
    localparam int DIV_DVD_W = 64;
    localparam int DIV_DVS_W = 32;

    // 1.0 in Q16.16
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAINING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM = 2'd2;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // work kinds after classification
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_INFER = 2'd1;
    localparam logic [1:0] KIND_TRAIN = 2'd2;

    typedef struct packed {
        logic               command;
        logic [7:0]         feature;
        logic signed [31:0] sample_value;
        logic               batch_last;
        logic signed [31:0] gamma_in;
        logic signed [31:0] beta_in;
    } item_t;

    typedef struct packed {
        logic signed [31:0] norm_value;
        logic [7:0]         out_feature;
        logic               out_last;
        logic               overflow_flag;
    } result_t;

    typedef struct packed {
        logic               training_mode;
        logic [15:0]        epsilon_q16;
        logic [16:0]        momentum_q16;
    } cfg_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [FIDX_MAX_W-1:0] fidx;
        logic [7:0]            feature;
        logic signed [31:0]    sample_value;
        logic                  batch_last;
        logic signed [31:0]    gamma_in;
        logic signed [31:0]    beta_in;
    } cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } div_rsp_t;

    // feature modulo table size, restoring subtract over the 8 feature bits
    function automatic logic [FIDX_MAX_W-1:0] feat_mod(input logic [7:0] f, input int features);
        int r;
        int k;
        r = int'(f);
        for (k = 7; k >= 0; k--)
        begin
            if (r >= (features << k))
            begin
                r = r - (features << k);
            end
        end
        return FIDX_MAX_W'(r);
    endfunction

endpackage

### hdl/bnf_front.sv
// Front end: takes input words, classifies them and feeds the command queue.
module bnf_front #(
    parameter int FEATURES = bnf_pkg::FEATURES_DEF
) (
    input  logic           push,
    output logic           full,
    input  bnf_pkg::item_t item,
    input  logic           training_mode,
    input  logic           clearing,
    input  logic           q_full,
    output logic           q_push,
    output bnf_pkg::cmd_t  q_data
);
    import bnf_pkg::*;

    // no intake while the tables are being cleared
    assign full   = q_full | clearing;
    assign q_push = push & ~full;

    // classify: load, immediate inference, or batch sample
    always_comb
    begin
        q_data.fidx         = feat_mod(item.feature, FEATURES);
        q_data.feature      = item.feature;
        q_data.sample_value = item.sample_value;
        q_data.batch_last   = item.batch_last;
        q_data.gamma_in     = item.gamma_in;
        q_data.beta_in      = item.beta_in;
        if (item.command == CMD_LOAD)
        begin
            q_data.kind = KIND_LOAD;
        end
        else if (training_mode)
        begin
            q_data.kind = KIND_TRAIN;
        end
        else
        begin
            q_data.kind = KIND_INFER;
        end
    end

endmodule

### hdl/bnf_queue.sv
// Short command queue between front and back.
module bnf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  bnf_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output bnf_pkg::cmd_t head,
    output logic          q_full,
    output logic          q_empty
);
    import bnf_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cmd_t             ent_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_full  = (count_reg == CNT_W'(Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign head    = ent_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/bnf_div.sv
// Restoring divider, one quotient bit per cycle.
module bnf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bnf_pkg::div_req_t req,
    output bnf_pkg::div_rsp_t rsp
);
    import bnf_pkg::*;

    localparam int CNT_W = $clog2(DIV_DVD_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_DVS_W-1:0] rem_reg;
    logic [DIV_DVD_W-1:0] quo_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;
    logic [DIV_DVS_W:0]   trial;
    logic [DIV_DVS_W+1:0] diff;
    logic                 ge;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[DIV_DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign ge    = ~diff[DIV_DVS_W+1];

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(DIV_DVD_W - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
            quo_reg <= {quo_reg[DIV_DVD_W-2:0], ge};
        end
    end

endmodule

### hdl/bnf_back.sv
// Back end: sample buffer, feature tables, statistics and normalization sequencer.
module bnf_back #(
    parameter int MAX_BATCH = bnf_pkg::MAX_BATCH_DEF,
    parameter int FEATURES  = bnf_pkg::FEATURES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bnf_pkg::cfg_t       cfg,
    input  logic                q_empty,
    input  bnf_pkg::cmd_t       q_head,
    output logic                q_pop,
    output logic                clearing,
    output bnf_pkg::div_req_t   div_req,
    input  bnf_pkg::div_rsp_t   div_rsp,
    input  logic                pop,
    output logic                empty,
    output bnf_pkg::result_t    result
);
    import bnf_pkg::*;

    localparam int BUF_AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int CNT_W  = $clog2(MAX_BATCH + 1);
    localparam int FIDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int SUM_W  = 32 + $clog2(MAX_BATCH) + 1;
    localparam int VSUM_W = 48 + $clog2(MAX_BATCH);

    // sequencer states
    localparam logic [4:0] ST_CLR    = 5'd0;
    localparam logic [4:0] ST_IDLE   = 5'd1;
    localparam logic [4:0] ST_TBL    = 5'd2;
    localparam logic [4:0] ST_S_WAIT = 5'd3;
    localparam logic [4:0] ST_S_ACC  = 5'd4;
    localparam logic [4:0] ST_DIVM   = 5'd5;
    localparam logic [4:0] ST_V_WAIT = 5'd6;
    localparam logic [4:0] ST_V_D    = 5'd7;
    localparam logic [4:0] ST_V_SQ   = 5'd8;
    localparam logic [4:0] ST_V_ACC  = 5'd9;
    localparam logic [4:0] ST_DIVV   = 5'd10;
    localparam logic [4:0] ST_R_INIT = 5'd11;
    localparam logic [4:0] ST_ROOT   = 5'd12;
    localparam logic [4:0] ST_BL_A   = 5'd13;
    localparam logic [4:0] ST_BL_B   = 5'd14;
    localparam logic [4:0] ST_BL_C   = 5'd15;
    localparam logic [4:0] ST_BL_D   = 5'd16;
    localparam logic [4:0] ST_BL_E   = 5'd17;
    localparam logic [4:0] ST_BL_F   = 5'd18;
    localparam logic [4:0] ST_N_WAIT = 5'd19;
    localparam logic [4:0] ST_N_D    = 5'd20;
    localparam logic [4:0] ST_N_MUL  = 5'd21;
    localparam logic [4:0] ST_N_DIV  = 5'd22;
    localparam logic [4:0] ST_N_OUT  = 5'd23;

    // control registers
    logic [4:0]        state_reg, state_next;
    logic [FIDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              drop_reg, drop_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              ph_reg, ph_next;
    logic              out_valid_reg, out_valid_next;

    // datapath registers
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               inf_reg, inf_next;
    logic [7:0]         feat_reg, feat_next;
    logic [FIDX_W-1:0]  fidx_reg, fidx_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] gam_reg, gam_next;
    logic signed [31:0] bet_reg, bet_next;
    logic signed [31:0] rmean_reg, rmean_next;
    logic [31:0]        rvar_reg, rvar_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [VSUM_W-1:0]  vsum_reg, vsum_next;
    logic signed [31:0] mean_reg, mean_next;
    logic [47:0]        var_reg, var_next;
    logic [31:0]        ad_reg, ad_next;
    logic [63:0]        sq_reg, sq_next;
    logic               neg_reg, neg_next;
    logic [63:0]        rad_reg, rad_next;
    logic [63:0]        rt_reg, rt_next;
    logic [63:0]        bitv_reg, bitv_next;
    logic [31:0]        s_reg, s_next;
    logic signed [50:0] blp_reg, blp_next;
    logic signed [50:0] blq_reg, blq_next;
    logic signed [31:0] nm_reg, nm_next;
    logic [63:0]        qv_reg, qv_next;
    result_t            out_reg, out_next;

    // memories
    logic [31:0] buf_mem [MAX_BATCH];
    logic [63:0] gb_mem  [FEATURES];
    logic [63:0] st_mem  [FEATURES];
    logic [31:0] buf_q;
    logic [63:0] gb_q;
    logic [63:0] st_q;

    logic              buf_we;
    logic              gb_we;
    logic              st_we;
    logic [FIDX_W-1:0] tbl_wa;
    logic [FIDX_W-1:0] tbl_ra;
    logic [63:0]       gb_wd;
    logic [63:0]       st_wd;
    logic              out_we;

    // helpers
    logic [16:0]        mom_c;
    logic [16:0]        om;
    logic [SUM_W-1:0]   sum_mag;
    logic signed [31:0] xs;
    logic signed [32:0] d33;
    logic [31:0]        dmag;
    logic [31:0]        gmag;
    logic [63:0]        sq_prod;
    logic signed [17:0] bl_a;
    logic signed [32:0] bl_b;
    logic signed [50:0] bl_prod;
    logic signed [50:0] bl_sum;
    logic [31:0]        vs;
    logic [48:0]        vpe;
    logic [63:0]        rt_try;
    logic [33:0]        qc;
    logic signed [35:0] sv;
    logic signed [35:0] rs;
    logic signed [31:0] sat;
    logic               is_last;

    assign clearing = (state_reg == ST_CLR);
    assign empty    = ~out_valid_reg;
    assign result   = out_reg;

    // momentum clamped to one and its complement
    assign mom_c = (cfg.momentum_q16 > ONE_Q16) ? ONE_Q16 : cfg.momentum_q16;
    assign om    = ONE_Q16 - mom_c;

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    // deviation from the mean and magnitudes
    assign xs   = inf_reg ? x_reg : $signed(buf_q);
    assign d33  = {xs[31], xs} - {mean_reg[31], mean_reg};
    assign dmag = d33[32] ? 32'(-d33) : d33[31:0];
    assign gmag = gam_reg[31] ? 32'(-gam_reg) : 32'(gam_reg);

    // shared 32x32 multiplier: squares and gamma products
    assign sq_prod = 64'(ad_reg) * 64'((state_reg == ST_N_MUL) ? gmag : ad_reg);

    // shared blend multiplier
    assign vs = (var_reg[47:32] != '0) ? 32'hFFFF_FFFF : var_reg[31:0];
    always_comb
    begin
        case (state_reg)
            ST_BL_A:
            begin
                bl_a = $signed({1'b0, om});
                bl_b = {rmean_reg[31], rmean_reg};
            end
            ST_BL_B:
            begin
                bl_a = $signed({1'b0, mom_c});
                bl_b = {mean_reg[31], mean_reg};
            end
            ST_BL_D:
            begin
                bl_a = $signed({1'b0, om});
                bl_b = $signed({1'b0, rvar_reg});
            end
            default:
            begin
                bl_a = $signed({1'b0, mom_c});
                bl_b = $signed({1'b0, vs});
            end
        endcase
    end
    assign bl_prod = bl_a * bl_b;
    assign bl_sum  = blp_reg + blq_reg;

    // variance plus epsilon, capped below 2^48
    assign vpe    = {1'b0, var_reg} + 49'(cfg.epsilon_q16);
    assign rt_try = rt_reg + bitv_reg;

    // signed quotient plus beta, saturated
    assign qc  = (qv_reg[63:34] != '0) ? 34'h3_FFFF_FFFF : qv_reg[33:0];
    assign sv  = neg_reg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    assign rs  = sv + 36'(bet_reg);
    always_comb
    begin
        if (rs[35:31] == 5'b00000 || rs[35:31] == 5'b11111)
        begin
            sat = rs[31:0];
        end
        else if (rs[35])
        begin
            sat = 32'sh8000_0000;
        end
        else
        begin
            sat = 32'sh7FFF_FFFF;
        end
    end
    assign is_last = inf_reg || (k_reg == n_reg - CNT_W'(1));

    assign tbl_ra = (state_reg == ST_IDLE) ? q_head.fidx[FIDX_W-1:0] : fidx_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        k_next         = k_reg;
        ph_next        = ph_reg;
        out_valid_next = out_valid_reg;
        n_next         = n_reg;
        inf_next       = inf_reg;
        feat_next      = feat_reg;
        fidx_next      = fidx_reg;
        x_next         = x_reg;
        gam_next       = gam_reg;
        bet_next       = bet_reg;
        rmean_next     = rmean_reg;
        rvar_next      = rvar_reg;
        sum_next       = sum_reg;
        vsum_next      = vsum_reg;
        mean_next      = mean_reg;
        var_next       = var_reg;
        ad_next        = ad_reg;
        sq_next        = sq_reg;
        neg_next       = neg_reg;
        rad_next       = rad_reg;
        rt_next        = rt_reg;
        bitv_next      = bitv_reg;
        s_next         = s_reg;
        blp_next       = blp_reg;
        blq_next       = blq_reg;
        nm_next        = nm_reg;
        qv_next        = qv_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        buf_we         = 1'b0;
        gb_we          = 1'b0;
        st_we          = 1'b0;
        tbl_wa         = fidx_reg;
        gb_wd          = {q_head.gamma_in, q_head.beta_in};
        st_wd          = {nm_reg, 32'h0};
        out_we         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = qv_reg;
        div_req.divisor  = s_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // table reset sweep
            ST_CLR:
            begin
                gb_we  = 1'b1;
                st_we  = 1'b1;
                tbl_wa = clr_cnt_reg;
                gb_wd  = {32'(ONE_Q16), 32'h0};
                st_wd  = '0;
                if (clr_cnt_reg == FIDX_W'(FEATURES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + FIDX_W'(1);
                end
            end

            // take one command word
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    k_next    = '0;
                    feat_next = q_head.feature;
                    fidx_next = q_head.fidx[FIDX_W-1:0];
                    x_next    = q_head.sample_value;
                    case (q_head.kind)
                        KIND_LOAD:
                        begin
                            gb_we  = 1'b1;
                            tbl_wa = q_head.fidx[FIDX_W-1:0];
                        end
                        KIND_INFER:
                        begin
                            inf_next   = 1'b1;
                            n_next     = CNT_W'(1);
                            state_next = ST_TBL;
                        end
                        KIND_TRAIN:
                        begin
                            inf_next = 1'b0;
                            if (cnt_reg < CNT_W'(MAX_BATCH))
                            begin
                                buf_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                            if (q_head.batch_last)
                            begin
                                n_next     = cnt_next;
                                state_next = ST_TBL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // latch the feature's tables
            ST_TBL:
            begin
                gam_next   = gb_q[63:32];
                bet_next   = gb_q[31:0];
                rmean_next = st_q[63:32];
                rvar_next  = st_q[31:0];
                if (inf_reg)
                begin
                    mean_next  = st_q[63:32];
                    var_next   = {16'h0, st_q[31:0]};
                    state_next = ST_R_INIT;
                end
                else
                begin
                    sum_next   = '0;
                    state_next = ST_S_WAIT;
                end
            end

            // sum pass
            ST_S_WAIT:
            begin
                state_next = ST_S_ACC;
            end
            ST_S_ACC:
            begin
                sum_next = sum_reg + SUM_W'($signed(buf_q));
                if (k_reg == n_reg - CNT_W'(1))
                begin
                    k_next     = '0;
                    ph_next    = 1'b0;
                    state_next = ST_DIVM;
                end
                else
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_S_WAIT;
                end
            end

            // mean = sum / n, toward zero
            ST_DIVM:
            begin
                div_req.dividend = DIV_DVD_W'(sum_mag);
                div_req.divisor  = DIV_DVS_W'(n_reg);
                if (!ph_reg)
                begin
                    div_req.start = 1'b1;
                    ph_next       = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    mean_next  = sum_reg[SUM_W-1] ? -div_rsp.quotient[31:0]
                                                  : div_rsp.quotient[31:0];
                    vsum_next  = '0;
                    ph_next    = 1'b0;
                    state_next = ST_V_WAIT;
                end
            end

            // squared deviation pass
            ST_V_WAIT:
            begin
                state_next = ST_V_D;
            end
            ST_V_D:
            begin
                ad_next    = dmag;
                state_next = ST_V_SQ;
            end
            ST_V_SQ:
            begin
                sq_next    = sq_prod;
                state_next = ST_V_ACC;
            end
            ST_V_ACC:
            begin
                vsum_next = vsum_reg + VSUM_W'(sq_reg[63:16]);
                if (k_reg == n_reg - CNT_W'(1))
                begin
                    k_next     = '0;
                    ph_next    = 1'b0;
                    state_next = ST_DIVV;
                end
                else
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ST_V_WAIT;
                end
            end

            // var = vsum / n
            ST_DIVV:
            begin
                div_req.dividend = DIV_DVD_W'(vsum_reg);
                div_req.divisor  = DIV_DVS_W'(n_reg);
                if (!ph_reg)
                begin
                    div_req.start = 1'b1;
                    ph_next       = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    var_next   = div_rsp.quotient[47:0];
                    ph_next    = 1'b0;
                    state_next = ST_R_INIT;
                end
            end

            // square root, two radicand bits per step
            ST_R_INIT:
            begin
                rad_next   = {(vpe[48] ? 48'hFFFF_FFFF_FFFF : vpe[47:0]), 16'h0};
                rt_next    = '0;
                bitv_next  = 64'h4000_0000_0000_0000;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (bitv_reg == '0)
                begin
                    s_next     = rt_reg[31:0];
                    k_next     = '0;
                    state_next = inf_reg ? ST_N_WAIT : ST_BL_A;
                end
                else
                begin
                    if (rad_reg >= rt_try)
                    begin
                        rad_next = rad_reg - rt_try;
                        rt_next  = (rt_reg >> 1) + bitv_reg;
                    end
                    else
                    begin
                        rt_next = rt_reg >> 1;
                    end
                    bitv_next = bitv_reg >> 2;
                end
            end

            // running statistics blend
            ST_BL_A:
            begin
                blp_next   = bl_prod;
                state_next = ST_BL_B;
            end
            ST_BL_B:
            begin
                blq_next   = bl_prod;
                state_next = ST_BL_C;
            end
            ST_BL_C:
            begin
                nm_next    = bl_sum[47:16];
                state_next = ST_BL_D;
            end
            ST_BL_D:
            begin
                blp_next   = bl_prod;
                state_next = ST_BL_E;
            end
            ST_BL_E:
            begin
                blq_next   = bl_prod;
                state_next = ST_BL_F;
            end
            ST_BL_F:
            begin
                st_we      = 1'b1;
                st_wd      = {nm_reg, ((bl_sum[50:48] != '0) ? 32'hFFFF_FFFF
                                                              : bl_sum[47:16])};
                state_next = ST_N_WAIT;
            end

            // normalize one sample
            ST_N_WAIT:
            begin
                state_next = ST_N_D;
            end
            ST_N_D:
            begin
                ad_next    = dmag;
                neg_next   = d33[32] ^ gam_reg[31];
                state_next = ST_N_MUL;
            end
            ST_N_MUL:
            begin
                sq_next    = sq_prod;
                ph_next    = 1'b0;
                state_next = ST_N_DIV;
            end
            ST_N_DIV:
            begin
                div_req.dividend = sq_reg;
                div_req.divisor  = s_reg;
                if (s_reg == '0)
                begin
                    qv_next    = '0;
                    state_next = ST_N_OUT;
                end
                else if (!ph_reg)
                begin
                    div_req.start = 1'b1;
                    ph_next       = 1'b1;
                end
                else if (div_rsp.done)
                begin
                    qv_next    = div_rsp.quotient;
                    ph_next    = 1'b0;
                    state_next = ST_N_OUT;
                end
            end
            ST_N_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_we                 = 1'b1;
                    out_valid_next         = 1'b1;
                    out_next.norm_value    = sat;
                    out_next.out_feature   = feat_reg;
                    out_next.out_last      = is_last;
                    out_next.overflow_flag = ~inf_reg & drop_reg;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                        if (!inf_reg)
                        begin
                            cnt_next  = '0;
                            drop_next = 1'b0;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_N_WAIT;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            k_reg         <= '0;
            ph_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            k_reg         <= k_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        inf_reg   <= inf_next;
        feat_reg  <= feat_next;
        fidx_reg  <= fidx_next;
        x_reg     <= x_next;
        gam_reg   <= gam_next;
        bet_reg   <= bet_next;
        rmean_reg <= rmean_next;
        rvar_reg  <= rvar_next;
        sum_reg   <= sum_next;
        vsum_reg  <= vsum_next;
        mean_reg  <= mean_next;
        var_reg   <= var_next;
        ad_reg    <= ad_next;
        sq_reg    <= sq_next;
        neg_reg   <= neg_next;
        rad_reg   <= rad_next;
        rt_reg    <= rt_next;
        bitv_reg  <= bitv_next;
        s_reg     <= s_next;
        blp_reg   <= blp_next;
        blq_reg   <= blq_next;
        nm_reg    <= nm_next;
        qv_reg    <= qv_next;
        if (out_we)
        begin
            out_reg <= out_next;
        end
    end

    // sample buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[cnt_reg[BUF_AW-1:0]] <= q_head.sample_value;
        end
        buf_q <= buf_mem[k_reg[BUF_AW-1:0]];
    end

    // gamma and beta table
    always_ff @(posedge clk)
    begin
        if (gb_we)
        begin
            gb_mem[tbl_wa] <= gb_wd;
        end
        gb_q <= gb_mem[tbl_ra];
    end

    // running mean and variance table
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[tbl_wa] <= st_wd;
        end
        st_q <= st_mem[tbl_ra];
    end

endmodule

### hdl/batch_norm_forward_unit.sv
// Top level of the batch normalization unit.
//
//  channel   handshake             payload
//  input     push / full           item   (item_t)
//  result    pop / empty           result (result_t)
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// The divider is used at most once per output and twice per batch. After reset
// a clearing pass sweeps the feature tables with full held high. A held result
// stalls only the back end; the front keeps filling the four-word queue.
`include "batch_norm_forward_unit_assert.svh"

module batch_norm_forward_unit #(
    parameter int MAX_BATCH = bnf_pkg::MAX_BATCH_DEF,
    parameter int FEATURES  = bnf_pkg::FEATURES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  bnf_pkg::item_t                   item,
    input  logic                             pop,
    output logic                             empty,
    output bnf_pkg::result_t                 result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bnf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bnf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bnf_pkg::*;

    logic        training_mode_reg;
    logic [15:0] epsilon_reg;
    logic [16:0] momentum_reg;
    cfg_t        cfg;

    logic     clearing;
    logic     q_full;
    logic     q_empty;
    logic     q_push;
    logic     q_pop;
    cmd_t     q_data;
    cmd_t     q_head;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            training_mode_reg <= 1'b1;
            epsilon_reg       <= 16'd1;
            momentum_reg      <= 17'd6554;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TRAINING: training_mode_reg <= cfg_data[0];
                CFG_EPSILON:  epsilon_reg       <= cfg_data[15:0];
                CFG_MOMENTUM: momentum_reg      <= cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.training_mode = training_mode_reg;
    assign cfg.epsilon_q16   = epsilon_reg;
    assign cfg.momentum_q16  = momentum_reg;

    bnf_front #(
        .FEATURES (FEATURES)
    ) u_front (
        .push          (push),
        .full          (full),
        .item          (item),
        .training_mode (training_mode_reg),
        .clearing      (clearing),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    bnf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_data),
        .rd_en   (q_pop),
        .head    (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    bnf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bnf_back #(
        .MAX_BATCH (MAX_BATCH),
        .FEATURES  (FEATURES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    // checks
    `BNF_ASSERT_NOW(a_clear_blocks_input, clearing, full, "input taken during table clear")
    `BNF_ASSERT_NEXT(a_clear_runs_once, !clearing, !clearing, "table clear restarted")
    `BNF_ASSERT_NOW(a_queue_no_overrun, q_push, !q_full, "command queue overrun")

endmodule
